>>> rtl/core/pxt_pkg.sv
// Package for the persistent XOR trie: transaction types, status and operation codes,
// and the fixed field widths and default sizes shared by the RTL and the checker.
// No dependencies.
`timescale 1ns / 1ps

package pxt_pkg;

    // Field widths fixed by the transaction format.
    localparam int unsigned VER_FIELD_BITS = 10;
    localparam int unsigned KEY_BITS       = 31;
    localparam int unsigned KEY_IDX_BITS   = $clog2(KEY_BITS);

    // Default sizes of the version table and the node pool.
    localparam int unsigned DEF_MAX_VERSIONS = 1024;
    localparam int unsigned DEF_POOL_NODES   = 65536;

    // Scale of the fixed-point reciprocal used to reduce a version number
    // modulo the table size.
    localparam int unsigned RECIP_SHIFT = 20;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERT_DONE = 2'd0,
        ST_QUERY_VALID = 2'd1,
        ST_POOL_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic [VER_FIELD_BITS-1:0] version_id;
        logic [VER_FIELD_BITS-1:0] parent_id;
        logic [KEY_BITS-1:0]       key;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [KEY_BITS-1:0] min_xor;
        logic [KEY_BITS-1:0] max_xor;
    } t_out_item;

endpackage

>>> rtl/core/pxt_node_mem.sv
// Node pool of the persistent XOR trie: one write port, two registered read ports.
// Node zero is the null node and always reads as zero; it is never written.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pxt_node_mem #(
    parameter int unsigned NW    = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_rd_addr_a,
    input  logic [NW-1:0] i_rd_addr_b,
    output logic [2*NW-1:0] o_rd_data_a,
    output logic [2*NW-1:0] o_rd_data_b,
    input  logic          i_wr_en,
    input  logic [NW-1:0] i_wr_addr,
    input  logic [2*NW-1:0] i_wr_data
);

    // Each word holds the left child index in its upper half and the right child
    // index in its lower half.
    logic [2*NW-1:0] r_mem [DEPTH];
    logic [2*NW-1:0] r_q_a;
    logic [2*NW-1:0] r_q_b;
    logic            r_null_a;
    logic            r_null_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q_a    <= r_mem[i_rd_addr_a];
        r_q_b    <= r_mem[i_rd_addr_b];
        r_null_a <= (i_rd_addr_a == '0);
        r_null_b <= (i_rd_addr_b == '0);
    end

    assign o_rd_data_a = r_null_a ? '0 : r_q_a;
    assign o_rd_data_b = r_null_b ? '0 : r_q_b;

endmodule

>>> rtl/core/persistent_xor_trie_top.sv
// Persistent XOR trie top level. An item runs through the states MODQ, MODR, ROOT,
// FETCH, one WALK step per key bit, LEAF for an insert, and DONE; an insert refused
// because the pool is full goes from ROOT straight to DONE. One item is in work at
// a time and the next is accepted at the earliest in the cycle after the result is
// loaded; the walk makes one node memory access per key bit. After reset the version
// table is cleared, during which no transaction is accepted.
`timescale 1ns / 1ps

module persistent_xor_trie_top
    import pxt_pkg::*;
#(
    parameter int unsigned MAX_VERSIONS = DEF_MAX_VERSIONS,
    parameter int unsigned POOL_NODES   = DEF_POOL_NODES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    // Width of a version table index, of a node index and of the allocation pointer,
    // which must be able to hold POOL_NODES itself.
    localparam int unsigned VW    = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
    localparam int unsigned NW    = $clog2(POOL_NODES);
    localparam int unsigned FW    = $clog2(POOL_NODES + 1);
    localparam int unsigned RECIP = (1 << RECIP_SHIFT) / MAX_VERSIONS;
    // An insert takes one fresh root plus one fresh node per key bit.
    localparam int unsigned PATH_NODES = KEY_BITS + 1;

    // The sequencer. One-hot codes.
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MODQ  = 9'b000000100,
        S_MODR  = 9'b000001000,
        S_ROOT  = 9'b000010000,
        S_FETCH = 9'b000100000,
        S_WALK  = 9'b001000000,
        S_LEAF  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Control registers.
    logic [VW-1:0] r_clr;
    logic [FW-1:0] r_next_free;
    logic          r_out_valid;

    // Payload registers of the item in work. Index 0 of the version arrays is the
    // version searched or created, index 1 the parent version.
    t_op                       r_op;
    logic [VER_FIELD_BITS-1:0] r_id_raw [2];
    logic [VER_FIELD_BITS-1:0] r_q      [2];
    logic [VW-1:0]             r_vidx   [2];
    logic [KEY_BITS-1:0]       r_key;
    logic [KEY_IDX_BITS-1:0]   r_lvl;
    logic [NW-1:0]             r_cur;
    logic [KEY_BITS-1:0]       r_lo;
    logic [KEY_BITS-1:0]       r_hi;
    t_status                   r_status;
    t_out_item                 r_out_data;

    // Version table: one root node index per version.
    logic [NW-1:0] r_root_mem [MAX_VERSIONS];
    logic [NW-1:0] r_root_q;

    logic          in_acc;
    logic          out_free;
    logic          pool_full;

    logic [VER_FIELD_BITS-1:0] n_q   [2];
    logic [VW-1:0]             n_idx [2];

    logic          root_we;
    logic [VW-1:0] root_wr_idx;
    logic [NW-1:0] root_wr_data;
    logic [VW-1:0] root_rd_idx;

    logic [2*NW-1:0] node_da;
    logic [2*NW-1:0] node_db;
    logic [NW-1:0]   node_rd_a;
    logic [NW-1:0]   node_rd_b;
    logic            node_we;
    logic [2*NW-1:0] node_wr_data;

    logic [NW-1:0] na_l, na_r, nb_l, nb_r;
    logic [NW-1:0] fresh;
    logic          kb;
    logic [NW-1:0] same_a, diff_a, same_b, diff_b;
    logic          min_bit;
    logic          max_bit;
    logic [NW-1:0] walk_a;
    logic [NW-1:0] walk_b;
    logic [2*NW-1:0] ins_word;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pool_full = r_next_free > FW'(POOL_NODES - PATH_NODES);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Version numbers are reduced modulo MAX_VERSIONS in two registered steps:
    // a quotient estimate from a fixed-point reciprocal, which is exact or one too
    // small, then the remainder with one correcting subtraction.
    always_comb begin
        logic [29:0] prod;
        logic [26:0] qd;
        logic [16:0] rem0;
        logic [16:0] rem1;
        for (int k = 0; k < 2; k++) begin
            prod     = 30'(r_id_raw[k]) * 30'(RECIP);
            n_q[k]   = prod[29:20];
            qd       = 27'(r_q[k]) * 27'(MAX_VERSIONS);
            rem0     = 17'(r_id_raw[k]) - 17'(qd);
            rem1     = (rem0 >= 17'(MAX_VERSIONS)) ? (rem0 - 17'(MAX_VERSIONS)) : rem0;
            n_idx[k] = VW'(rem1);
        end
    end

    // Version table port usage. The clearing pass writes zeros; an insert writes the
    // new root in the cycle after the parent's root is read, so an insert onto its own
    // version still starts from the old root.
    always_comb begin
        root_we      = 1'b0;
        root_wr_idx  = r_vidx[0];
        root_wr_data = NW'(r_next_free);
        if (r_state == S_CLEAR) begin
            root_we      = 1'b1;
            root_wr_idx  = r_clr;
            root_wr_data = '0;
        end else if (r_state == S_FETCH && r_op == OP_INSERT) begin
            root_we = 1'b1;
        end
        root_rd_idx = (r_op == OP_QUERY) ? r_vidx[0] : r_vidx[1];
    end

    always_ff @(posedge i_clk) begin
        if (root_we) begin
            r_root_mem[root_wr_idx] <= root_wr_data;
        end
        r_root_q <= r_root_mem[root_rd_idx];
    end

    // One trie level per cycle. Port A follows the parent path for an insert and the
    // minimum path for a query; port B follows the maximum path. Inserts only write
    // freshly allocated nodes and only read older ones, so a read never meets a
    // write to the same node.
    assign na_l = node_da[2*NW-1:NW];
    assign na_r = node_da[NW-1:0];
    assign nb_l = node_db[2*NW-1:NW];
    assign nb_r = node_db[NW-1:0];
    assign kb   = r_key[KEY_BITS-1];
    assign fresh = r_cur + NW'(1);

    always_comb begin
        same_a  = kb ? na_r : na_l;
        diff_a  = kb ? na_l : na_r;
        same_b  = kb ? nb_r : nb_l;
        diff_b  = kb ? nb_l : nb_r;
        // Minimum follows the matching bit when that child exists.
        min_bit = (same_a == '0);
        // Maximum follows the opposite bit when that child exists.
        max_bit = (diff_b != '0);
        ins_word = kb ? {na_l, fresh} : {fresh, na_r};
        if (r_op == OP_INSERT) begin
            walk_a = same_a;
        end else begin
            walk_a = min_bit ? diff_a : same_a;
        end
        walk_b = max_bit ? diff_b : same_b;
    end

    assign node_rd_a    = (r_state == S_FETCH) ? r_root_q : walk_a;
    assign node_rd_b    = (r_state == S_FETCH) ? r_root_q : walk_b;
    assign node_we      = ((r_state == S_WALK) && (r_op == OP_INSERT)) || (r_state == S_LEAF);
    assign node_wr_data = (r_state == S_LEAF) ? '0 : ins_word;

    pxt_node_mem #(
        .NW    (NW),
        .DEPTH (POOL_NODES)
    ) u_node_mem (
        .i_clk       (i_clk),
        .i_rd_addr_a (node_rd_a),
        .i_rd_addr_b (node_rd_b),
        .o_rd_data_a (node_da),
        .o_rd_data_b (node_db),
        .i_wr_en     (node_we),
        .i_wr_addr   (r_cur),
        .i_wr_data   (node_wr_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == VW'(MAX_VERSIONS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MODQ;
                end
            end
            S_MODQ: begin
                n_state = S_MODR;
            end
            S_MODR: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_op == OP_INSERT && pool_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_lvl == '0) begin
                    n_state = (r_op == OP_INSERT) ? S_LEAF : S_DONE;
                end
            end
            S_LEAF: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: state, clearing counter, allocation pointer, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= FW'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + VW'(1);
            end
            // The leaf is the last node of the path, so the pointer moves past it.
            if (r_state == S_LEAF) begin
                r_next_free <= FW'(r_cur) + FW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_in_data.op;
            r_id_raw[0] <= i_in_data.version_id;
            r_id_raw[1] <= i_in_data.parent_id;
            r_key       <= i_in_data.key;
        end
        if (r_state == S_MODQ) begin
            r_q[0] <= n_q[0];
            r_q[1] <= n_q[1];
        end
        if (r_state == S_MODR) begin
            r_vidx[0] <= n_idx[0];
            r_vidx[1] <= n_idx[1];
        end
        if (r_state == S_ROOT) begin
            if (r_op == OP_QUERY) begin
                r_status <= ST_QUERY_VALID;
            end else if (pool_full) begin
                r_status <= ST_POOL_FULL;
            end else begin
                r_status <= ST_INSERT_DONE;
            end
        end
        if (r_state == S_FETCH) begin
            r_cur <= NW'(r_next_free);
            r_lvl <= KEY_IDX_BITS'(KEY_BITS - 1);
            r_lo  <= '0;
            r_hi  <= '0;
        end
        if (r_state == S_WALK) begin
            r_cur <= fresh;
            r_lvl <= r_lvl - KEY_IDX_BITS'(1);
            r_key <= {r_key[KEY_BITS-2:0], 1'b0};
            r_lo  <= {r_lo[KEY_BITS-2:0], min_bit};
            r_hi  <= {r_hi[KEY_BITS-2:0], max_bit};
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data.status  <= r_status;
            r_out_data.min_xor <= (r_op == OP_QUERY) ? r_lo : '0;
            r_out_data.max_xor <= (r_op == OP_QUERY) ? r_hi : '0;
        end
    end

endmodule

>>> rtl/core/pxt_checker.sv
// Port-level checker for the persistent XOR trie and the bind that attaches it.
// Depends on pxt_pkg and persistent_xor_trie_top.
`timescale 1ns / 1ps

module pxt_checker
    import pxt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A result waiting on a stalled consumer holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Only one item is in work: after a transaction is taken the input stalls.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // A result never appears in the cycle right after an input transaction.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Insert results carry zero in both XOR fields.
    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_QUERY_VALID)
        |-> (o_out_data.min_xor == '0) && (o_out_data.max_xor == '0))
        else $error("insert result has nonzero XOR fields");

endmodule

bind persistent_xor_trie_top pxt_checker u_pxt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

>>> dv/testbench.sv
// Self-checking testbench for the persistent XOR trie top level (persistent_xor_trie_top).
// Depends on pxt_pkg for the transaction types and codes; a behavioral trie in this file
// predicts every result, and the design's outputs are compared against it.
`timescale 1ns / 1ps

module testbench;
    import pxt_pkg::*;

    localparam int unsigned VERSIONS    = DEF_MAX_VERSIONS;
    localparam int unsigned POOL        = DEF_POOL_NODES;
    // An accepted insert takes one new root plus one node per key bit.
    localparam int unsigned PATH_NODES  = KEY_BITS + 1;
    // The drain at the end waits this long after the last expected result has arrived.
    localparam int unsigned TAIL_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    persistent_xor_trie_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral trie. Each version is a root index; every node holds the
    // index of its zero child and its one child, and node zero is the
    // null node. Inserts copy the path of the parent version, so all
    // other subtrees stay shared between versions.
    // ------------------------------------------------------------------
    int unsigned root_of [VERSIONS];
    int unsigned zero_kid [POOL];
    int unsigned one_kid [POOL];
    int unsigned alloc_next;

    // Expected results, oldest first, one per accepted transaction.
    t_out_item pending_results [$];
    // Keys inserted lately; random keys are often drawn close to them so that
    // walks share long prefixes and branch deep in the trie.
    logic [KEY_BITS-1:0] recent_keys [$];

    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned hold_len_req = 0;
    int unsigned hold_left    = 0;
    int unsigned rx_left      = 0;

    function automatic int unsigned fresh_node();
        int unsigned n;
        n = (alloc_next < POOL) ? alloc_next : 0;
        alloc_next++;
        zero_kid[n] = 0;
        one_kid[n]  = 0;
        return n;
    endfunction

    // Applies one transaction to the behavioral trie and returns the result
    // that the design must produce for it.
    function automatic t_out_item trie_predict(t_in_item it);
        t_out_item   r;
        int unsigned ver, par, src, cur, nxt;
        int unsigned a, b, a_same, a_diff, b_same, b_diff;
        logic        kb;
        r   = '0;
        ver = it.version_id % VERSIONS;
        par = it.parent_id % VERSIONS;
        if (it.op == OP_INSERT) begin
            if (alloc_next > POOL || POOL - alloc_next < PATH_NODES) begin
                // No room for a whole path: nothing changes.
                r.status = ST_POOL_FULL;
            end else begin
                r.status = ST_INSERT_DONE;
                // The parent root is read before the new root is stored, so an
                // insert onto the same version keeps the old keys.
                src = root_of[par];
                cur = fresh_node();
                root_of[ver] = cur;
                for (int i = KEY_BITS - 1; i >= 0; i--) begin
                    nxt = fresh_node();
                    if (it.key[i]) begin
                        zero_kid[cur] = zero_kid[src];
                        one_kid[cur]  = nxt;
                        src = one_kid[src];
                    end else begin
                        one_kid[cur]  = one_kid[src];
                        zero_kid[cur] = nxt;
                        src = zero_kid[src];
                    end
                    cur = nxt;
                end
            end
        end else begin
            r.status = ST_QUERY_VALID;
            a = root_of[ver];
            b = a;
            // Two walks: the minimum follows the key's own bit where it can, the
            // maximum the opposite bit. An empty version stays on the null node,
            // which gives a minimum of all ones and a maximum of zero.
            for (int i = KEY_BITS - 1; i >= 0; i--) begin
                kb     = it.key[i];
                a_same = kb ? one_kid[a] : zero_kid[a];
                a_diff = kb ? zero_kid[a] : one_kid[a];
                b_same = kb ? one_kid[b] : zero_kid[b];
                b_diff = kb ? zero_kid[b] : one_kid[b];
                if (a_same != 0) begin
                    a = a_same;
                end else begin
                    r.min_xor[i] = 1'b1;
                    a = a_diff;
                end
                if (b_diff != 0) begin
                    r.max_xor[i] = 1'b1;
                    b = b_diff;
                end else begin
                    b = b_same;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(t_op op, int unsigned ver, int unsigned par,
                                           logic [KEY_BITS-1:0] key);
        t_in_item r;
        r.op         = op;
        r.version_id = ver[VER_FIELD_BITS-1:0];
        r.parent_id  = par[VER_FIELD_BITS-1:0];
        r.key        = key;
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        logic [31:0]         flip;
        int unsigned         sel, span;
        sel = $urandom_range(0, 9);
        if (sel < 4 || recent_keys.size() == 0) begin
            k = KEY_BITS'($urandom);
        end else if (sel < 8) begin
            // Near a recent key: only the low bits differ.
            span = $urandom_range(0, KEY_BITS);
            flip = $urandom & ((32'h1 << span) - 32'h1);
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)] ^ flip[KEY_BITS-1:0];
        end else if (sel == 8) begin
            case ($urandom_range(0, 3))
                0: k = '0;
                1: k = KEY_ONES;
                2: k = 31'h1 << $urandom_range(0, KEY_BITS - 1);
                default: k = ~(31'h1 << $urandom_range(0, KEY_BITS - 1));
            endcase
        end else begin
            k = KEY_BITS'($urandom >> $urandom_range(1, KEY_BITS - 1));
        end
        return k;
    endfunction

    // Most versions come from a small hot set so that chains of versions grow
    // long; the rest cover the whole range, including versions never written.
    function automatic int unsigned pick_version();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31)
                                          : $urandom_range(0, VERSIONS - 1);
    endfunction

    function automatic t_in_item random_item(int unsigned query_pct);
        t_op                 op;
        logic [KEY_BITS-1:0] k;
        op = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_INSERT;
        k  = pick_key();
        if (op == OP_INSERT) begin
            recent_keys = {recent_keys, k};
            if (recent_keys.size() > 16) begin
                void'(recent_keys.pop_front());
            end
        end
        return make_item(op, pick_version(), pick_version(), k);
    endfunction

    // Offers one transaction and returns at the clock edge that accepts it.
    // Valid is left high there, so a following transaction with no gap goes
    // out on the next cycle without valid dropping in between.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        t_out_item   exp_res;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        exp_res = trie_predict(it);
        pending_results = {pending_results, exp_res};
    endtask

    task automatic note_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes, both operations, and every special case of the trie:
    // empty and never written versions, insert onto itself, overwriting a
    // version, duplicate keys, and persistence of older versions.
    task automatic test_directed();
        send_item(make_item(OP_QUERY, 0, 0, '0));
        send_item(make_item(OP_QUERY, VERSIONS - 1, VERSIONS - 1, KEY_ONES));
        send_item(make_item(OP_INSERT, 0, 0, '0));
        send_item(make_item(OP_QUERY, 0, 0, '0));
        send_item(make_item(OP_QUERY, 0, 0, KEY_ONES));
        send_item(make_item(OP_INSERT, 1, 0, KEY_ONES));
        send_item(make_item(OP_QUERY, 1, 0, '0));
        send_item(make_item(OP_QUERY, 1, 0, 31'h2AAA_AAAA));
        send_item(make_item(OP_INSERT, 1, 1, 31'h1555_5555));
        send_item(make_item(OP_QUERY, 1, 7, 31'h1555_5554));
        // An empty version extended by itself.
        send_item(make_item(OP_INSERT, VERSIONS - 1, VERSIONS - 1, 31'h4000_0000));
        send_item(make_item(OP_QUERY, VERSIONS - 1, 0, 31'h0000_0001));
        send_item(make_item(OP_INSERT, 5, VERSIONS - 1, 31'h0000_0001));
        send_item(make_item(OP_QUERY, 5, 0, 31'h4000_0001));
        send_item(make_item(OP_QUERY, 5, 0, 31'h3FFF_FFFE));
        // Overwrite version 1 from a parent that was never written.
        send_item(make_item(OP_INSERT, 1, 500, 31'h1234_5678));
        send_item(make_item(OP_QUERY, 1, 0, 31'h1234_5678));
        send_item(make_item(OP_QUERY, 0, 0, KEY_ONES));
        // The same key stored twice along one chain.
        send_item(make_item(OP_INSERT, 3, 0, '0));
        send_item(make_item(OP_QUERY, 3, VERSIONS - 1, 31'h0000_0100));
        send_item(make_item(OP_QUERY, 600, 0, 31'h0F0F_0F0F));
    endtask

    // Random inserts and queries; idling on each side is switched on and off
    // in stretches so that some runs go at full rate.
    task automatic test_random_mix(input int unsigned count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_item(random_item(45));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver stops taking results for a long stretch while transactions
    // keep coming with no gap, so the design backs up and stalls its input.
    task automatic test_output_hold();
        tx_idle_on   = 1'b0;
        hold_len_req = 300;
        repeat (12) send_item(random_item(50));
        tx_idle_on = 1'b1;
    endtask

    // Inserts until the node pool cannot take another path, then checks that
    // further inserts are refused and that the versions queried afterwards are unchanged.
    task automatic test_pool_exhaustion();
        int unsigned v, n;
        n = 0;
        while (alloc_next <= POOL && POOL - alloc_next >= PATH_NODES) begin
            if (n % 50 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_item(random_item(10));
            n++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        v = pick_version();
        send_item(make_item(OP_INSERT, v, v, pick_key()));
        send_item(make_item(OP_QUERY, v, 0, pick_key()));
        send_item(make_item(OP_INSERT, VERSIONS - 1, 0, KEY_ONES));
        send_item(make_item(OP_INSERT, 0, VERSIONS - 1, '0));
        repeat (10) send_item(random_item(50));
    endtask

    // ------------------------------------------------------------------
    // Receiver. After each result it draws how many cycles to stall the next
    // one; that count runs down only while a result is waiting. A hold
    // request from a test overrides it with one long stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_left = 0;
        end else begin
            if (hold_len_req != 0) begin
                hold_left    = hold_len_req;
                hold_len_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (o_out_valid === 1'b1 && !i_out_stall) begin
                    rx_left = rx_idle_on ? $urandom_range(0, 5) : 0;
                end else if (o_out_valid === 1'b1 && rx_left != 0) begin
                    rx_left--;
                end
                i_out_stall <= (rx_left != 0);
            end
        end
    end

    // Result checker: every result transaction is compared field by field
    // with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                note_error("status of a result with no transaction pending", 'x,
                           o_out_data.status);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    note_error("status", want.status, o_out_data.status);
                end
                if (o_out_data.min_xor !== want.min_xor) begin
                    note_error("min_xor", want.min_xor, o_out_data.min_xor);
                end
                if (o_out_data.max_xor !== want.max_xor) begin
                    note_error("max_xor", want.max_xor, o_out_data.max_xor);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int v = 0; v < VERSIONS; v++) begin
            root_of[v] = 0;
        end
        zero_kid[0] = 0;
        one_kid[0]  = 0;
        alloc_next  = 2;

        // Hold reset, then release it; the design then clears its version table and
        // stalls its input meanwhile, which the first send simply waits out.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(300);
        test_output_hold();
        test_pool_exhaustion();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
